// ===== hw/rtl/qsl_pkg.sv =====
// Shared types and constants for the quaternion slerp core.
package qsl_pkg;

   localparam int CompW  = 16;
   localparam int CordW  = 34;
   localparam int AngW   = 32;
   localparam int RootW  = 31;
   localparam int SqW    = 61;
   localparam int NumW   = 63;
   localparam int QuotW  = 48;
   localparam int RemW   = 31;
   localparam int AtanLen = 32;

   localparam logic [AngW-1:0] PiQ30      = 32'd3373259426;
   localparam logic [AngW-1:0] HalfPiQ30  = 32'd1686629713;
   localparam logic [AngW-1:0] InvGainQ30 = 32'd652032874;
   localparam logic [RootW-1:0] OneQ30    = 31'h4000_0000;

   localparam logic [AngW-1:0] AtanTab [AtanLen] = '{
      32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
      32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
      32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
      32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255,
      32'd127, 32'd63, 32'd31, 32'd15, 32'd7, 32'd3, 32'd1, 32'd0, 32'd0
   };

   typedef struct packed {
      logic [3:0][CompW-1:0] qa;
      logic [3:0][CompW-1:0] qb;
      logic [CompW-1:0]      blend;
      logic                  degen;
   } side_type;

   typedef struct packed {
      logic [3:0][CompW-1:0] comp;
      logic                  degen;
   } result_type;

   localparam int SideW = $bits(side_type);

endpackage

// ===== hw/rtl/quaternion_slerp_core.sv =====
// Pipelined quaternion slerp: dot product, sqrt, CORDIC angle and sines, divide, blend.
//
//  channel | ports  | tdata fields (lsb first)                            | tuser
//  --------+--------+-----------------------------------------------------+-----------
//  request | req_*  | a_x a_y a_z a_w b_x b_y b_z b_w blend, 16 bit each  | -
//  result  | rsp_*  | out_x out_y out_z out_w, 16 bit each                | degenerate
//
//  One item enters per clock while the output buffer has room; rsp_tvalid comes
//  after the 31 root stages, two CORDIC chains and the 48 divider stages.
//  Reset clears all valid bits and the two-entry output buffer; no item is lost.
//  The whole pipe advances together while the output buffer has room, so
//  req_tready only depends on registered buffer occupancy.
module quaternion_slerp_core #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [143:0] req_tdata,   // a_x a_y a_z a_w b_x b_y b_z b_w blend
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,   // out_x out_y out_z out_w
   output logic [0:0]   rsp_tuser    // degenerate
);

   localparam int CordW = qsl_pkg::CordW;
   localparam int AngW  = qsl_pkg::AngW;
   localparam int RootW = qsl_pkg::RootW;
   localparam int SqW   = qsl_pkg::SqW;
   localparam int NumW  = qsl_pkg::NumW;
   localparam int QuotW = qsl_pkg::QuotW;
   localparam int SideW = qsl_pkg::SideW;
   localparam int N     = CORDIC_STEPS;

   localparam logic signed [33:0] DMax  = 34'sd1073741824;
   localparam logic signed [66:0] Round = 67'sd536870912;

   logic en;
   logic [1:0] cnt_ff, cnt_in;

   assign en         = (cnt_ff != 2'd2);
   assign req_tready = en;

   // stage 1: products
   qsl_pkg::side_type  s1_side_in, s1_side_ff;
   logic signed [31:0] s1_prod_in [4];
   logic signed [31:0] s1_prod_ff [4];
   logic               s1_v_ff;

   always_comb begin
      s1_side_in.blend = (req_tdata[143:128] > 16'd32768) ? 16'd32768 : req_tdata[143:128];
      s1_side_in.degen = 1'b0;
      for (int k = 0; k < 4; k++) begin
         s1_side_in.qa[k] = req_tdata[16*k +: 16];
         s1_side_in.qb[k] = req_tdata[64+16*k +: 16];
         s1_prod_in[k]    = $signed(req_tdata[16*k +: 16]) * $signed(req_tdata[64+16*k +: 16]);
      end
   end

   // stage 2: dot product and clamp
   logic signed [33:0] s2_sum;
   logic signed [31:0] s2_d_in, s2_d_ff;
   qsl_pkg::side_type  s2_side_ff;
   logic               s2_v_ff;

   always_comb begin
      s2_sum = 34'(s1_prod_ff[0]) + 34'(s1_prod_ff[1]) + 34'(s1_prod_ff[2])
             + 34'(s1_prod_ff[3]);
      if (s2_sum > DMax) begin
         s2_d_in = 32'(DMax);
      end else if (s2_sum < -DMax) begin
         s2_d_in = 32'(-DMax);
      end else begin
         s2_d_in = s2_sum[31:0];
      end
   end

   // stage 3: d squared
   logic signed [63:0] s3_sq_in;
   logic [SqW-1:0]     s3_dsq_ff;
   logic signed [31:0] s3_d_ff;
   qsl_pkg::side_type  s3_side_ff;
   logic               s3_v_ff;

   assign s3_sq_in = s2_d_ff * s2_d_ff;

   // stage 4: one minus d squared
   logic [RootW-1:0]   s4_ss_in, s4_ss_ff;
   logic signed [31:0] s4_d_ff;
   qsl_pkg::side_type  s4_side_in, s4_side_ff;
   logic               s4_v_ff;

   always_comb begin
      s4_ss_in         = qsl_pkg::OneQ30 - s3_dsq_ff[SqW-1:30];
      s4_side_in       = s3_side_ff;
      s4_side_in.degen = (s4_ss_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req_tvalid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_side_ff <= s1_side_in;
         s1_prod_ff <= s1_prod_in;
         s2_side_ff <= s1_side_ff;
         s2_d_ff    <= s2_d_in;
         s3_side_ff <= s2_side_ff;
         s3_d_ff    <= s2_d_ff;
         s3_dsq_ff  <= s3_sq_in[SqW-1:0];
         s4_side_ff <= s4_side_in;
         s4_d_ff    <= s3_d_ff;
         s4_ss_ff   <= s4_ss_in;
      end
   end

   // square root of ss in Q30
   logic                   sq_v;
   logic [RootW-1:0]       sq_root;
   logic [SideW+31:0]      sq_side;
   qsl_pkg::side_type      sq_sd;
   logic signed [31:0]     sq_d;

   qsl_isqrt #(
      .SW (SideW + 32)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s4_v_ff),
      .in_sq     ({s4_ss_ff, 30'd0}),
      .in_side   ({s4_side_ff, s4_d_ff}),
      .out_valid (sq_v),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   assign sq_sd = sq_side[SideW+31:32];
   assign sq_d  = $signed(sq_side[31:0]);

   // vectoring CORDIC for the angle
   logic                    vv_ff   [N+1];
   logic signed [CordW-1:0] vx_ff   [N+1];
   logic signed [CordW-1:0] vy_ff   [N+1];
   logic signed [CordW-1:0] vz_ff   [N+1];
   logic [RootW-1:0]        vsp_ff  [N+1];
   qsl_pkg::side_type       vside_ff [N+1];
   logic signed [CordW-1:0] v0_x_in, v0_y_in, v0_z_in;

   always_comb begin
      if (sq_d >= 0) begin
         v0_x_in = CordW'(sq_d);
         v0_y_in = $signed(CordW'(sq_root));
         v0_z_in = '0;
      end else begin
         v0_x_in = $signed(CordW'(sq_root));
         v0_y_in = -CordW'(sq_d);
         v0_z_in = $signed(CordW'(qsl_pkg::HalfPiQ30));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vv_ff[0] <= 1'b0;
      end else if (en) begin
         vv_ff[0] <= sq_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vx_ff[0]    <= v0_x_in;
         vy_ff[0]    <= v0_y_in;
         vz_ff[0]    <= v0_z_in;
         vsp_ff[0]   <= sq_root;
         vside_ff[0] <= sq_sd;
      end
   end

   for (genvar j = 0; j < N; j++) begin : g_vec
      localparam logic signed [CordW-1:0] AtanStep = CordW'(qsl_pkg::AtanTab[j]);
      logic signed [CordW-1:0] x_in, y_in, z_in;

      always_comb begin
         if (vy_ff[j] > 0) begin
            x_in = vx_ff[j] + (vy_ff[j] >>> j);
            y_in = vy_ff[j] - (vx_ff[j] >>> j);
            z_in = vz_ff[j] + AtanStep;
         end else begin
            x_in = vx_ff[j] - (vy_ff[j] >>> j);
            y_in = vy_ff[j] + (vx_ff[j] >>> j);
            z_in = vz_ff[j] - AtanStep;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vv_ff[j+1] <= 1'b0;
         end else if (en) begin
            vv_ff[j+1] <= vv_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            vx_ff[j+1]    <= x_in;
            vy_ff[j+1]    <= y_in;
            vz_ff[j+1]    <= z_in;
            vsp_ff[j+1]   <= vsp_ff[j];
            vside_ff[j+1] <= vside_ff[j];
         end
      end
   end

   // angle clamp, t*ph, remainder, fold
   logic [AngW-1:0]   c_ph_in, c_ph_ff, m_ph_ff, m_pt_ff, r_pt_ff, r_rest_ff;
   logic [47:0]       m_prod;
   logic [AngW-1:0]   r_rest_in;
   logic [AngW-1:0]   f_th_in [2];
   logic [RootW-1:0]  c_sp_ff, m_sp_ff, r_sp_ff;
   qsl_pkg::side_type c_side_ff, m_side_ff, r_side_ff;
   logic              c_v_ff, m_v_ff, r_v_ff;

   always_comb begin
      if (vz_ff[N] < 0) begin
         c_ph_in = '0;
      end else if (vz_ff[N] > $signed(CordW'(qsl_pkg::PiQ30))) begin
         c_ph_in = qsl_pkg::PiQ30;
      end else begin
         c_ph_in = vz_ff[N][AngW-1:0];
      end
   end

   assign m_prod    = 48'(c_ph_ff) * 48'(c_side_ff.blend);
   assign r_rest_in = m_ph_ff - m_pt_ff;

   always_comb begin
      f_th_in[0] = (r_rest_ff > qsl_pkg::HalfPiQ30) ? qsl_pkg::PiQ30 - r_rest_ff : r_rest_ff;
      f_th_in[1] = (r_pt_ff > qsl_pkg::HalfPiQ30) ? qsl_pkg::PiQ30 - r_pt_ff : r_pt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
         m_v_ff <= 1'b0;
         r_v_ff <= 1'b0;
      end else if (en) begin
         c_v_ff <= vv_ff[N];
         m_v_ff <= c_v_ff;
         r_v_ff <= m_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_ph_ff   <= c_ph_in;
         c_sp_ff   <= vsp_ff[N];
         c_side_ff <= vside_ff[N];
         m_ph_ff   <= c_ph_ff;
         m_pt_ff   <= m_prod[46:15];
         m_sp_ff   <= c_sp_ff;
         m_side_ff <= c_side_ff;
         r_rest_ff <= r_rest_in;
         r_pt_ff   <= m_pt_ff;
         r_sp_ff   <= m_sp_ff;
         r_side_ff <= m_side_ff;
      end
   end

   // rotation CORDIC, lane 0 sin(rest), lane 1 sin(pt)
   logic                    sv_ff    [N+1];
   logic signed [CordW-1:0] sx_ff    [N+1][2];
   logic signed [CordW-1:0] sy_ff    [N+1][2];
   logic signed [CordW-1:0] sz_ff    [N+1][2];
   logic [RootW-1:0]        ssp_ff   [N+1];
   qsl_pkg::side_type       sside_ff [N+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff[0] <= 1'b0;
      end else if (en) begin
         sv_ff[0] <= r_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ssp_ff[0]   <= r_sp_ff;
         sside_ff[0] <= r_side_ff;
         for (int l = 0; l < 2; l++) begin
            sx_ff[0][l] <= $signed(CordW'(qsl_pkg::InvGainQ30));
            sy_ff[0][l] <= '0;
            sz_ff[0][l] <= $signed(CordW'(f_th_in[l]));
         end
      end
   end

   for (genvar j = 0; j < N; j++) begin : g_sin
      localparam logic signed [CordW-1:0] AtanStep = CordW'(qsl_pkg::AtanTab[j]);
      logic signed [CordW-1:0] x_in [2];
      logic signed [CordW-1:0] y_in [2];
      logic signed [CordW-1:0] z_in [2];

      always_comb begin
         for (int l = 0; l < 2; l++) begin
            if (sz_ff[j][l] >= 0) begin
               x_in[l] = sx_ff[j][l] - (sy_ff[j][l] >>> j);
               y_in[l] = sy_ff[j][l] + (sx_ff[j][l] >>> j);
               z_in[l] = sz_ff[j][l] - AtanStep;
            end else begin
               x_in[l] = sx_ff[j][l] + (sy_ff[j][l] >>> j);
               y_in[l] = sy_ff[j][l] - (sx_ff[j][l] >>> j);
               z_in[l] = sz_ff[j][l] + AtanStep;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[j+1] <= 1'b0;
         end else if (en) begin
            sv_ff[j+1] <= sv_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ssp_ff[j+1]   <= ssp_ff[j];
            sside_ff[j+1] <= sside_ff[j];
            for (int l = 0; l < 2; l++) begin
               sx_ff[j+1][l] <= x_in[l];
               sy_ff[j+1][l] <= y_in[l];
               sz_ff[j+1][l] <= z_in[l];
            end
         end
      end
   end

   // sign and magnitude ahead of the divider
   logic              g_neg_in [2];
   logic              g_neg_ff [2];
   logic [CordW-1:0]  g_mag    [2];
   logic [NumW-1:0]   g_num_in [2];
   logic [NumW-1:0]   g_num_ff [2];
   logic [RootW-1:0]  g_sp_ff;
   qsl_pkg::side_type g_side_ff;
   logic              g_v_ff;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         g_neg_in[l] = sy_ff[N][l][CordW-1];
         g_mag[l]    = g_neg_in[l] ? -sy_ff[N][l] : sy_ff[N][l];
         g_num_in[l] = {g_mag[l][CordW-2:0], 30'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_v_ff <= 1'b0;
      end else if (en) begin
         g_v_ff <= sv_ff[N];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         g_neg_ff  <= g_neg_in;
         g_num_ff  <= g_num_in;
         g_sp_ff   <= ssp_ff[N];
         g_side_ff <= sside_ff[N];
      end
   end

   logic              dv_v;
   logic [QuotW-1:0]  dv_q0, dv_q1;
   logic [SideW+1:0]  dv_side;
   qsl_pkg::side_type dv_sd;

   qsl_divide #(
      .SW (SideW + 2)
   ) u_divide (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (g_v_ff),
      .in_num0   (g_num_ff[0]),
      .in_num1   (g_num_ff[1]),
      .in_den    (g_sp_ff),
      .in_side   ({g_side_ff, g_neg_ff[0], g_neg_ff[1]}),
      .out_valid (dv_v),
      .out_quo0  (dv_q0),
      .out_quo1  (dv_q1),
      .out_side  (dv_side)
   );

   assign dv_sd = dv_side[SideW+1:2];

   // signed weights
   logic signed [QuotW:0] w_w0_in, w_w1_in, w_w0_ff, w_w1_ff;
   qsl_pkg::side_type     w_side_ff;
   logic                  w_v_ff;

   always_comb begin
      w_w0_in = dv_side[1] ? -$signed({1'b0, dv_q0}) : $signed({1'b0, dv_q0});
      w_w1_in = dv_side[0] ? -$signed({1'b0, dv_q1}) : $signed({1'b0, dv_q1});
   end

   // partial products, weight split at bit 24
   logic signed [40:0] p_ah_in [4], p_al_in [4], p_bh_in [4], p_bl_in [4];
   logic signed [40:0] p_ah_ff [4], p_al_ff [4], p_bh_ff [4], p_bl_ff [4];
   qsl_pkg::side_type  p_side_ff;
   logic               p_v_ff;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         p_ah_in[k] = $signed(w_side_ff.qa[k]) * $signed(w_w0_ff[QuotW:24]);
         p_al_in[k] = $signed(w_side_ff.qa[k]) * $signed({1'b0, w_w0_ff[23:0]});
         p_bh_in[k] = $signed(w_side_ff.qb[k]) * $signed(w_w1_ff[QuotW:24]);
         p_bl_in[k] = $signed(w_side_ff.qb[k]) * $signed({1'b0, w_w1_ff[23:0]});
      end
   end

   // partial sums
   logic signed [41:0] x_hi_in [4], x_lo_in [4], x_hi_ff [4], x_lo_ff [4];
   qsl_pkg::side_type  x_side_ff;
   logic               x_v_ff;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         x_hi_in[k] = 42'(p_ah_ff[k]) + 42'(p_bh_ff[k]);
         x_lo_in[k] = 42'(p_al_ff[k]) + 42'(p_bl_ff[k]);
      end
   end

   // round, saturate, degenerate bypass
   logic signed [66:0]  o_acc [4];
   logic signed [36:0]  o_val [4];
   qsl_pkg::result_type o_res_in, o_res_ff;
   logic                o_v_ff;

   always_comb begin
      o_res_in.degen = x_side_ff.degen;
      for (int k = 0; k < 4; k++) begin
         o_acc[k] = (67'(x_hi_ff[k]) <<< 24) + 67'(x_lo_ff[k]) + Round;
         o_val[k] = o_acc[k][66:30];
         if (x_side_ff.degen) begin
            o_res_in.comp[k] = x_side_ff.qa[k];
         end else if (o_val[k] > 37'sd32767) begin
            o_res_in.comp[k] = 16'h7fff;
         end else if (o_val[k] < -37'sd32768) begin
            o_res_in.comp[k] = 16'h8000;
         end else begin
            o_res_in.comp[k] = o_val[k][15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_v_ff <= 1'b0;
         p_v_ff <= 1'b0;
         x_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
      end else if (en) begin
         w_v_ff <= dv_v;
         p_v_ff <= w_v_ff;
         x_v_ff <= p_v_ff;
         o_v_ff <= x_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w_w0_ff   <= w_w0_in;
         w_w1_ff   <= w_w1_in;
         w_side_ff <= dv_sd;
         p_ah_ff   <= p_ah_in;
         p_al_ff   <= p_al_in;
         p_bh_ff   <= p_bh_in;
         p_bl_ff   <= p_bl_in;
         p_side_ff <= w_side_ff;
         x_hi_ff   <= x_hi_in;
         x_lo_ff   <= x_lo_in;
         x_side_ff <= p_side_ff;
         o_res_ff  <= o_res_in;
      end
   end

   // two-entry output buffer
   qsl_pkg::result_type hd_ff, hd_in, tl_ff, tl_in;
   logic                push, pop;

   assign push = en && o_v_ff;
   assign pop  = rsp_tvalid && rsp_tready;

   always_comb begin
      hd_in  = hd_ff;
      tl_in  = tl_ff;
      cnt_in = cnt_ff;
      unique case ({push, pop})
         2'b11: begin
            if (cnt_ff == 2'd1) begin
               hd_in = o_res_ff;
            end else begin
               hd_in = tl_ff;
               tl_in = o_res_ff;
            end
         end
         2'b10: begin
            if (cnt_ff == 2'd0) begin
               hd_in = o_res_ff;
            end else begin
               tl_in = o_res_ff;
            end
            cnt_in = cnt_ff + 2'd1;
         end
         2'b01: begin
            hd_in  = tl_ff;
            cnt_in = cnt_ff - 2'd1;
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      hd_ff <= hd_in;
      tl_ff <= tl_in;
   end

   assign rsp_tvalid   = (cnt_ff != 2'd0);
   assign rsp_tdata    = hd_ff.comp;
   assign rsp_tuser[0] = hd_ff.degen;

endmodule

// ===== hw/rtl/qsl_isqrt.sv =====
// Pipelined integer square root, one root bit per stage, with sideband.
module qsl_isqrt #(
   parameter int SW = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [qsl_pkg::SqW-1:0]     in_sq,
   input  logic [SW-1:0]               in_side,
   output logic                        out_valid,
   output logic [qsl_pkg::RootW-1:0]   out_root,
   output logic [SW-1:0]               out_side
);

   localparam int RootW = qsl_pkg::RootW;
   localparam int SqW   = qsl_pkg::SqW;

   logic             v_ff    [RootW];
   logic [RootW-1:0] r_ff    [RootW];
   logic [SqW-1:0]   rem_ff  [RootW];
   logic [SW-1:0]    side_ff [RootW];

   for (genvar j = 0; j < RootW; j++) begin : g_stage
      localparam int K = RootW - 1 - j;
      logic             v_prev;
      logic [RootW-1:0] r_prev;
      logic [SqW-1:0]   rem_prev;
      logic [SW-1:0]    side_prev;
      logic [63:0]      trial;
      logic [RootW-1:0] r_in;
      logic [SqW-1:0]   rem_in;

      if (j == 0) begin : g_first
         always_comb begin
            v_prev    = in_valid;
            r_prev    = '0;
            rem_prev  = in_sq;
            side_prev = in_side;
         end
      end else begin : g_next
         always_comb begin
            v_prev    = v_ff[j-1];
            r_prev    = r_ff[j-1];
            rem_prev  = rem_ff[j-1];
            side_prev = side_ff[j-1];
         end
      end

      // root bits above K only, so the OR is an add
      always_comb begin
         trial  = (64'(r_prev) << (K + 1)) | (64'd1 << (2 * K));
         r_in   = r_prev;
         rem_in = rem_prev;
         if (64'(rem_prev) >= trial) begin
            rem_in  = rem_prev - trial[SqW-1:0];
            r_in[K] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (en) begin
            v_ff[j] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[j]    <= r_in;
            rem_ff[j]  <= rem_in;
            side_ff[j] <= side_prev;
         end
      end
   end

   assign out_valid = v_ff[RootW-1];
   assign out_root  = r_ff[RootW-1];
   assign out_side  = side_ff[RootW-1];

endmodule

// ===== hw/rtl/qsl_divide.sv =====
// Two-lane pipelined restoring divider sharing one divisor, one quotient bit per stage.
module qsl_divide #(
   parameter int SW = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [qsl_pkg::NumW-1:0]    in_num0,
   input  logic [qsl_pkg::NumW-1:0]    in_num1,
   input  logic [qsl_pkg::RootW-1:0]   in_den,
   input  logic [SW-1:0]               in_side,
   output logic                        out_valid,
   output logic [qsl_pkg::QuotW-1:0]   out_quo0,
   output logic [qsl_pkg::QuotW-1:0]   out_quo1,
   output logic [SW-1:0]               out_side
);

   localparam int NumW  = qsl_pkg::NumW;
   localparam int QuotW = qsl_pkg::QuotW;
   localparam int RemW  = qsl_pkg::RemW;
   localparam int RootW = qsl_pkg::RootW;

   logic             v_ff    [QuotW];
   logic [RemW-1:0]  rem_ff  [QuotW][2];
   logic [QuotW-1:0] quo_ff  [QuotW][2];
   logic [NumW-1:0]  num_ff  [QuotW][2];
   logic [RootW-1:0] den_ff  [QuotW];
   logic [SW-1:0]    side_ff [QuotW];

   for (genvar j = 0; j < QuotW; j++) begin : g_stage
      localparam int K = QuotW - 1 - j;
      logic             v_prev;
      logic [RemW-1:0]  rem_prev [2];
      logic [QuotW-1:0] quo_prev [2];
      logic [NumW-1:0]  num_prev [2];
      logic [RootW-1:0] den_prev;
      logic [SW-1:0]    side_prev;
      logic [RemW:0]    part     [2];
      logic [RemW:0]    diff     [2];
      logic [RemW-1:0]  rem_in   [2];
      logic [QuotW-1:0] quo_in   [2];

      if (j == 0) begin : g_first
         // top bits stay below the divisor for any valid item
         always_comb begin
            v_prev      = in_valid;
            num_prev[0] = in_num0;
            num_prev[1] = in_num1;
            rem_prev[0] = RemW'(in_num0[NumW-1:QuotW]);
            rem_prev[1] = RemW'(in_num1[NumW-1:QuotW]);
            quo_prev[0] = '0;
            quo_prev[1] = '0;
            den_prev    = in_den;
            side_prev   = in_side;
         end
      end else begin : g_next
         always_comb begin
            v_prev    = v_ff[j-1];
            den_prev  = den_ff[j-1];
            side_prev = side_ff[j-1];
            for (int l = 0; l < 2; l++) begin
               num_prev[l] = num_ff[j-1][l];
               rem_prev[l] = rem_ff[j-1][l];
               quo_prev[l] = quo_ff[j-1][l];
            end
         end
      end

      always_comb begin
         for (int l = 0; l < 2; l++) begin
            part[l]   = {rem_prev[l], num_prev[l][K]};
            diff[l]   = part[l] - {1'b0, den_prev};
            quo_in[l] = quo_prev[l];
            if (part[l] >= {1'b0, den_prev}) begin
               rem_in[l]    = diff[l][RemW-1:0];
               quo_in[l][K] = 1'b1;
            end else begin
               rem_in[l]    = part[l][RemW-1:0];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (en) begin
            v_ff[j] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[j]  <= den_prev;
            side_ff[j] <= side_prev;
            for (int l = 0; l < 2; l++) begin
               rem_ff[j][l] <= rem_in[l];
               quo_ff[j][l] <= quo_in[l];
               num_ff[j][l] <= num_prev[l];
            end
         end
      end
   end

   assign out_valid = v_ff[QuotW-1];
   assign out_quo0  = quo_ff[QuotW-1][0];
   assign out_quo1  = quo_ff[QuotW-1][1];
   assign out_side  = side_ff[QuotW-1];

endmodule

// ===== hw/rtl/qsl_checker.sv =====
// Port-level checks for the quaternion slerp core, bound to the top level.
module qsl_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [63:0]  rsp_tdata,
   input logic [0:0]   rsp_tuser
);

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_stall_full : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result waiting");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("buffer not empty after reset");

endmodule

bind quaternion_slerp_core qsl_checker u_qsl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/tb_quaternion_slerp_core.sv =====
// Testbench for the quaternion slerp core: random and directed items checked against a predictor.
module tb_quaternion_slerp_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Latency = 94 + 2 * 16;

   typedef struct {
      logic [15:0] comp [4];
      logic        degen;
   } slerp_result_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [143:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [63:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;

   logic [143:0]     pending_items [$];
   slerp_result_type expected_slerps [$];
   int               fail_count = 0;
   bit               hold_sender = 1'b0;
   bit               calm_phase = 1'b0;
   bit               req_taken = 1'b0;

   const longint AtanQ30 [16] = '{
      843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
      16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
      65535, 32767
   };
   localparam longint OneQ30 = 64'sd1073741824;
   localparam longint PiQ30 = 64'sd3373259426;
   localparam longint HalfPiQ30 = 64'sd1686629713;

   quaternion_slerp_core DUT (.*);

   always #5 clock = ~clock;

   function automatic longint int_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return longint'(r);
   endfunction

   function automatic longint phase_angle(longint x, longint y, longint z);
      longint xn;
      for (int i = 0; i < 16; i++) begin
         if (y > 0) begin
            xn = x + (y >>> i);
            y = y - (x >>> i);
            z += AtanQ30[i];
         end else begin
            xn = x - (y >>> i);
            y = y + (x >>> i);
            z -= AtanQ30[i];
         end
         x = xn;
      end
      return z;
   endfunction

   function automatic longint sine_q30(longint th);
      longint x, y, z, xn;
      x = 652032874;
      y = 0;
      if (th > HalfPiQ30) th = PiQ30 - th;
      z = th;
      for (int i = 0; i < 16; i++) begin
         if (z >= 0) begin
            xn = x - (y >>> i);
            y = y + (x >>> i);
            z -= AtanQ30[i];
         end else begin
            xn = x + (y >>> i);
            y = y - (x >>> i);
            z += AtanQ30[i];
         end
         x = xn;
      end
      return y;
   endfunction

   function automatic slerp_result_type predict_slerp(logic [143:0] item);
      slerp_result_type r;
      longint qa [4], qb [4];
      longint d, ss, sp, ph, pt, w0, w1, acc;
      longint unsigned t;
      d = 0;
      for (int k = 0; k < 4; k++) begin
         qa[k] = longint'($signed(item[16*k +: 16]));
         qb[k] = longint'($signed(item[64 + 16*k +: 16]));
         d += qa[k] * qb[k];
      end
      t = item[143:128];
      if (t > 32768) t = 32768;
      if (d > OneQ30) d = OneQ30;
      if (d < -OneQ30) d = -OneQ30;
      ss = OneQ30 - longint'(longint'(d * d) >> 30);
      if (ss <= 0) begin
         for (int k = 0; k < 4; k++) r.comp[k] = qa[k][15:0];
         r.degen = 1'b1;
         return r;
      end
      sp = int_sqrt(longint'(ss) << 30);
      if (d >= 0) ph = phase_angle(d, sp, 0);
      else ph = phase_angle(sp, -d, HalfPiQ30);
      if (ph < 0) ph = 0;
      if (ph > PiQ30) ph = PiQ30;
      pt = longint'((longint'(ph) * longint'(t)) >> 15);
      w1 = (sine_q30(pt) * OneQ30) / sp;
      w0 = (sine_q30(ph - pt) * OneQ30) / sp;
      for (int k = 0; k < 4; k++) begin
         acc = (qa[k] * w0 + qb[k] * w1 + (64'sd1 <<< 29)) >>> 30;
         if (acc > 32767) acc = 32767;
         if (acc < -32768) acc = -32768;
         r.comp[k] = acc[15:0];
      end
      r.degen = 1'b0;
      return r;
   endfunction

   function automatic logic [143:0] pack_item(logic [15:0] a [4], logic [15:0] b [4],
                                              logic [15:0] blend);
      return {blend, b[3], b[2], b[1], b[0], a[3], a[2], a[1], a[0]};
   endfunction

   // unit quaternion-ish component: norm small enough that d never clips
   function automatic logic [15:0] unit_comp();
      return 16'($signed($urandom_range(0, 32766)) - 16383);
   endfunction

   function automatic logic [15:0] rand_blend();
      case ($urandom_range(0, 9))
         0: return 16'd0;
         1: return 16'd32768;
         2: return 16'($urandom);
         default: return 16'($urandom_range(0, 32768));
      endcase
   endfunction

   // acceptance is decided at the rising edge
   always @(posedge clock) begin
      req_taken <= !reset && req_tvalid && req_tready;
   end

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken) begin
            expected_slerps.push_back(predict_slerp(req_tdata));
         end
         if (!(req_tvalid && !req_taken)) begin
            if (pending_items.size() > 0 && !hold_sender &&
                (calm_phase || $urandom_range(0, 99) >= 17)) begin
               req_tdata <= pending_items.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= calm_phase || $urandom_range(0, 99) >= 17;
      end
   end

   // monitor
   always @(posedge clock) begin
      slerp_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_slerps.size() == 0) begin
            $error("result with nothing expected: %h %b", rsp_tdata, rsp_tuser);
            fail_count++;
         end else begin
            want = expected_slerps.pop_front();
            for (int k = 0; k < 4; k++) begin
               if (rsp_tdata[16*k +: 16] !== want.comp[k]) begin
                  $error("out_%0s expected %0d actual %0d", k == 0 ? "x" : k == 1 ? "y" :
                         k == 2 ? "z" : "w", $signed(want.comp[k]),
                         $signed(rsp_tdata[16*k +: 16]));
                  fail_count++;
               end
            end
            if (rsp_tuser[0] !== want.degen) begin
               $error("degenerate expected %0b actual %0b", want.degen, rsp_tuser[0]);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #20ms;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      logic [15:0] a [4], b [4];
      int n;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // extremes of the fields
      a = '{16'h8000, 16'h8000, 16'h8000, 16'h8000};
      b = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff};
      pending_items.push_back(pack_item(a, b, 16'hffff));
      pending_items.push_back(pack_item(a, a, 16'd0));
      pending_items.push_back(pack_item(b, b, 16'd32768));
      pending_items.push_back(pack_item(b, a, 16'd16384));
      // d of one quarter, then unit quaternions: degenerate with d exactly one and minus one
      a = '{16'd0, 16'd0, 16'd0, 16'h4000};
      b = '{16'd0, 16'd0, 16'h4000, 16'd0};
      pending_items.push_back(pack_item(a, a, 16'd12345));
      a = '{16'h4000, 16'h4000, 16'h4000, 16'h4000};
      b = '{16'hc000, 16'hc000, 16'hc000, 16'hc000};
      pending_items.push_back(pack_item(a, a, 16'd100));
      pending_items.push_back(pack_item(a, b, 16'd8000));
      // orthogonal and near-degenerate
      a = '{16'd0, 16'd0, 16'd0, 16'h7fff};
      b = '{16'd0, 16'd0, 16'h7fff, 16'd0};
      pending_items.push_back(pack_item(a, b, 16'd16384));
      b = '{16'd1, 16'd0, 16'd0, 16'h7fff};
      pending_items.push_back(pack_item(a, b, 16'd16384));
      b = '{16'd0, 16'd0, 16'd0, 16'h0000};
      pending_items.push_back(pack_item(a, b, 16'd32769));
      pending_items.push_back(pack_item(b, b, 16'd20000));
      for (int k = 0; k < 4; k++) a[k] = 16'h7fff;
      for (int k = 0; k < 4; k++) b[k] = 16'h0001 << k;
      pending_items.push_back(pack_item(a, b, 16'd1));

      // pause until the pipe has drained
      wait (pending_items.size() == 0);
      hold_sender = 1'b1;
      wait (expected_slerps.size() == 0 && !req_tvalid);
      @(negedge clock);
      hold_sender = 1'b0;

      for (n = 0; n < 1800; n++) begin
         if (n == 600) begin
            wait (pending_items.size() == 0);
            calm_phase = 1'b1;
         end
         if (n == 900) begin
            wait (pending_items.size() == 0);
            calm_phase = 1'b0;
         end
         case ($urandom_range(0, 9))
            0, 1: begin
               for (int k = 0; k < 4; k++) a[k] = 16'($urandom);
               for (int k = 0; k < 4; k++) b[k] = 16'($urandom);
            end
            2: begin
               for (int k = 0; k < 4; k++) a[k] = unit_comp();
               b = a;
               b[$urandom_range(0, 3)] ^= 16'($urandom_range(0, 3));
            end
            3: begin
               for (int k = 0; k < 4; k++) a[k] = unit_comp();
               for (int k = 0; k < 4; k++) b[k] = -a[k];
            end
            default: begin
               for (int k = 0; k < 4; k++) a[k] = unit_comp();
               for (int k = 0; k < 4; k++) b[k] = unit_comp();
            end
         endcase
         pending_items.push_back(pack_item(a, b, rand_blend()));
         if (pending_items.size() > 64) wait (pending_items.size() < 32);
      end

      wait (pending_items.size() == 0 && !req_tvalid);
      fork
         wait (expected_slerps.size() == 0);
         #1ms;
      join_any
      disable fork;
      repeat (Latency + 20) @(posedge clock);
      if (fail_count == 0 && expected_slerps.size() == 0) begin
         $display("TB_OK");
      end else begin
         if (expected_slerps.size() != 0) $error("%0d results missing", expected_slerps.size());
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

// ===== files.f =====
hw/rtl/qsl_pkg.sv
hw/rtl/qsl_isqrt.sv
hw/rtl/qsl_divide.sv
hw/rtl/quaternion_slerp_core.sv
hw/rtl/qsl_checker.sv
tb/tb_quaternion_slerp_core.sv
